@@ hw/rtl/etsc_pkg.sv @@
// ----------------------------------------------------------------------------
// etsc_pkg
// Shared types and constants for the elapsed-time clock and speed controller.
// ----------------------------------------------------------------------------
package etsc_pkg;

  // request codes carried in req_type
  localparam logic [2:0] REQ_TICK       = 3'd0;
  localparam logic [2:0] REQ_SPEED_UP   = 3'd1;
  localparam logic [2:0] REQ_SPEED_DOWN = 3'd2;
  localparam logic [2:0] REQ_STOP       = 3'd3;
  localparam logic [2:0] REQ_RESUME     = 3'd4;
  localparam logic [2:0] REQ_CLEAR      = 3'd5;

  // configuration register indexes
  localparam logic CFG_TICKS_PER_SECOND = 1'b0;
  localparam logic CFG_DUTY_STEP        = 1'b1;

  localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd489;
  localparam logic [7:0]  DUTY_STEP_RESET        = 8'd25;
  localparam logic [7:0]  DUTY_LEVEL_RESET       = 8'd25;
  localparam logic [7:0]  DUTY_MAX               = 8'd255;

  localparam logic [3:0] ONES_MAX      = 4'd9;
  localparam logic [2:0] TENS_MAX      = 3'd5;
  localparam logic [3:0] HOUR_ONES_END = 4'd3;
  localparam logic [1:0] HOUR_TENS_END = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic       presence;
  } in_t;

  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic [3:0] hour_ones;
    logic [1:0] hour_tens;
    logic [7:0] pwm_duty;
    logic       motor_on;
    logic       clock_running;
  } out_t;

endpackage

@@ hw/rtl/exercise_timer_speed_controller_unit.sv @@
// ----------------------------------------------------------------------------
// exercise_timer_speed_controller_unit
// Elapsed-time clock in BCD plus PWM duty control, one request per beat.
// ----------------------------------------------------------------------------
//
//  channel | signals                      | dir | payload
//  --------+------------------------------+-----+------------------------------
//  in      | in_valid / in_ready          | in  | etsc_pkg::in_t (request)
//  out     | out_valid / out_ready        | out | etsc_pkg::out_t (status)
//  cfg     | cfg_valid / cfg_ready        | in  | cfg_index, cfg_data
//
//  The state update and the status word are formed in one
//  pass of logic and land in the state registers and the output register on
//  the accepting edge. The time keeping is held directly as BCD digits.
//  A new beat is taken every cycle while the output register is empty or
//  being drained; a stall on out holds the result and blocks in.
//  Synchronous reset restores the clock, duty and configuration defaults.
//  cfg is always ready.
module exercise_timer_speed_controller_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  etsc_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output etsc_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [15:0] ticks_per_second;
  logic [7:0]  duty_step;

  logic [15:0] prescale_count, prescale_count_next;
  logic [3:0]  sec_ones, sec_ones_next;
  logic [2:0]  sec_tens, sec_tens_next;
  logic [3:0]  min_ones, min_ones_next;
  logic [2:0]  min_tens, min_tens_next;
  logic [3:0]  hour_ones, hour_ones_next;
  logic [1:0]  hour_tens, hour_tens_next;
  logic [7:0]  duty_level, duty_level_next;
  logic        running, running_next;

  logic        in_fire;
  logic [15:0] prescale_inc;
  logic [8:0]  duty_sum;
  logic        sec_carry, min_carry;

  etsc_pkg::out_t result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= etsc_pkg::TICKS_PER_SECOND_RESET;
      duty_step        <= etsc_pkg::DUTY_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        etsc_pkg::CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        etsc_pkg::CFG_DUTY_STEP:        duty_step        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign prescale_inc = prescale_count + 16'd1;
  assign duty_sum     = {1'b0, duty_level} + {1'b0, duty_step};
  assign sec_carry    = (sec_ones == etsc_pkg::ONES_MAX) && (sec_tens == etsc_pkg::TENS_MAX);
  assign min_carry    = (min_ones == etsc_pkg::ONES_MAX) && (min_tens == etsc_pkg::TENS_MAX);

  always_comb begin
    prescale_count_next = prescale_count;
    sec_ones_next       = sec_ones;
    sec_tens_next       = sec_tens;
    min_ones_next       = min_ones;
    min_tens_next       = min_tens;
    hour_ones_next      = hour_ones;
    hour_tens_next      = hour_tens;
    duty_level_next     = duty_level;
    running_next        = running;
    case (in_data.req_type)
      etsc_pkg::REQ_TICK: begin
        if (running) begin
          if (prescale_inc == ticks_per_second) begin
            prescale_count_next = '0;
            // seconds -> minutes -> hours ripple, hours wrap at 24
            if (sec_ones == etsc_pkg::ONES_MAX) begin
              sec_ones_next = '0;
              sec_tens_next = (sec_tens == etsc_pkg::TENS_MAX) ? 3'd0 : sec_tens + 3'd1;
            end else begin
              sec_ones_next = sec_ones + 4'd1;
            end
            if (sec_carry) begin
              if (min_ones == etsc_pkg::ONES_MAX) begin
                min_ones_next = '0;
                min_tens_next = (min_tens == etsc_pkg::TENS_MAX) ? 3'd0 : min_tens + 3'd1;
              end else begin
                min_ones_next = min_ones + 4'd1;
              end
              if (min_carry) begin
                if (hour_tens == etsc_pkg::HOUR_TENS_END &&
                    hour_ones == etsc_pkg::HOUR_ONES_END) begin
                  hour_ones_next = '0;
                  hour_tens_next = '0;
                end else if (hour_ones == etsc_pkg::ONES_MAX) begin
                  hour_ones_next = '0;
                  hour_tens_next = hour_tens + 2'd1;
                end else begin
                  hour_ones_next = hour_ones + 4'd1;
                end
              end
            end
          end else begin
            prescale_count_next = prescale_inc;
          end
        end
      end
      etsc_pkg::REQ_SPEED_UP: begin
        duty_level_next = duty_sum[8] ? etsc_pkg::DUTY_MAX : duty_sum[7:0];
      end
      etsc_pkg::REQ_SPEED_DOWN: begin
        duty_level_next = (duty_level > duty_step) ? duty_level - duty_step : 8'd0;
      end
      etsc_pkg::REQ_STOP: begin
        if (in_data.presence) running_next = 1'b0;
      end
      etsc_pkg::REQ_RESUME: begin
        if (in_data.presence) running_next = 1'b1;
      end
      etsc_pkg::REQ_CLEAR: begin
        // prescaler and run flag are left alone
        if (in_data.presence) begin
          sec_ones_next  = '0;
          sec_tens_next  = '0;
          min_ones_next  = '0;
          min_tens_next  = '0;
          hour_ones_next = '0;
          hour_tens_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.sec_ones      = sec_ones_next;
    result.sec_tens      = sec_tens_next;
    result.min_ones      = min_ones_next;
    result.min_tens      = min_tens_next;
    result.hour_ones     = hour_ones_next;
    result.hour_tens     = hour_tens_next;
    result.pwm_duty      = in_data.presence ? duty_level_next : 8'd0;
    result.motor_on      = in_data.presence;
    result.clock_running = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      sec_ones       <= '0;
      sec_tens       <= '0;
      min_ones       <= '0;
      min_tens       <= '0;
      hour_ones      <= '0;
      hour_tens      <= '0;
      duty_level     <= etsc_pkg::DUTY_LEVEL_RESET;
      running        <= 1'b1;
    end else if (in_fire) begin
      prescale_count <= prescale_count_next;
      sec_ones       <= sec_ones_next;
      sec_tens       <= sec_tens_next;
      min_ones       <= min_ones_next;
      min_tens       <= min_tens_next;
      hour_ones      <= hour_ones_next;
      hour_tens      <= hour_tens_next;
      duty_level     <= duty_level_next;
      running        <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_data <= result;
  end

  a_digits_in_range: assert property (@(posedge clk) disable iff (rst)
    sec_ones <= etsc_pkg::ONES_MAX && sec_tens <= etsc_pkg::TENS_MAX &&
    min_ones <= etsc_pkg::ONES_MAX && min_tens <= etsc_pkg::TENS_MAX &&
    (hour_tens < etsc_pkg::HOUR_TENS_END ||
     (hour_tens == etsc_pkg::HOUR_TENS_END && hour_ones <= etsc_pkg::HOUR_ONES_END)))
    else $error("time digits out of range");

  a_no_drive_without_presence: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.motor_on |-> out_data.pwm_duty == 8'd0)
    else $error("pwm duty nonzero without presence");

  a_stop_clears_run: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.req_type == etsc_pkg::REQ_STOP && in_data.presence
    |=> !running && !out_data.clock_running)
    else $error("stop press did not halt the clock");

  a_stalled_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result is stalled");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(in_fire) |-> $stable(duty_level) && $stable(prescale_count))
    else $error("state changed without an accepted beat");

endmodule
